[hdl/bafrd_pkg.sv]
package bafrd_pkg;

    // Position width default and the fixed field widths
    localparam int POS_BITS_DEF = 24;
    localparam int NOW_BITS     = 32;
    localparam int ALLOW_BITS   = 31;
    localparam int DIST_BITS    = 24;
    localparam int SPEED_BITS   = 16;
    localparam int STATUS_BITS  = 2;

    localparam logic [DIST_BITS-1:0] DIST_SAT = {DIST_BITS{1'b1}};

    // Shared multiplier operands and square-root unit sizes
    localparam int MUL_BITS  = DIST_BITS;
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int RAD_BITS  = PROD_BITS + 2;
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int REM_BITS  = ROOT_BITS + 3;

    // Configuration registers
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int FLOOR_BITS    = 15;
    localparam int CEIL_BITS     = 15;
    localparam int ACCEL_BITS    = 16;
    localparam int TARGET_BITS   = 8;
    localparam int STROKE_BITS   = 16;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPEED_FLOOR   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPEED_CEILING = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ACCEL_LIMIT   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CYCLE_TARGET  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_STROKE_LENGTH = 3'd4;

    localparam logic [FLOOR_BITS-1:0]  FLOOR_RST  = 15'd100;
    localparam logic [CEIL_BITS-1:0]   CEIL_RST   = 15'd500;
    localparam logic [ACCEL_BITS-1:0]  ACCEL_RST  = 16'd2500;
    localparam logic [TARGET_BITS-1:0] TARGET_RST = 8'd3;
    localparam logic [STROKE_BITS-1:0] STROKE_RST = 16'd300;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_RUNNING   = 2'd0,
        STATUS_SUCCEEDED = 2'd1,
        STATUS_FAILED    = 2'd2
    } status_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } command_t;

endpackage

[hdl/bafrd_mul.sv]
module bafrd_mul (
    input  logic                           aclk,
    input  logic [bafrd_pkg::MUL_BITS-1:0]  mul_a,
    input  logic [bafrd_pkg::MUL_BITS-1:0]  mul_b,
    output logic [bafrd_pkg::PROD_BITS-1:0] mul_p
);
    import bafrd_pkg::*;

    logic [PROD_BITS-1:0] prod_reg;

    // Register the product; the operands are chosen by the sequencer state
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    end

    assign mul_p = prod_reg;

endmodule

[hdl/bafrd_sqrt.sv]
module bafrd_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [bafrd_pkg::RAD_BITS-1:0]  radicand,
    output logic                           done,
    output logic [bafrd_pkg::ROOT_BITS-1:0] root
);
    import bafrd_pkg::*;

    localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [RAD_BITS-1:0]  rad_reg, rad_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic [REM_BITS-1:0]  rem_sh;
    logic [REM_BITS-1:0]  trial;

    // One result bit per cycle: bring down two radicand bits, try root*4+1
    assign rem_sh = {rem_reg[REM_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial  = REM_BITS'({root_reg, 2'b01});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(ROOT_BITS);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next = {rad_reg[RAD_BITS-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
            end
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hdl/back_and_forth_recovery_drive_core.sv]
// Start beats and ticks that stop, succeed or fail early go from decide straight to emit;
// a full tick gives its result after squaring both offsets and two 25-step square roots
// on the shared root unit (only one when the distance saturates), plus the other states.
// Input is taken only in idle, so a beat is worked on only once the last is in the output
// register; input is taken again once back in idle, even while that result waits.
// Reset (aresetn, synchronous, low): registers to defaults, run state cleared.
module back_and_forth_recovery_drive_core #(
    parameter int POS_BITS = bafrd_pkg::POS_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [bafrd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [bafrd_pkg::CFG_DATA_BITS-1:0] cfg_wdata,

    // Input stream
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata, low bit up: pos_x, pos_y, now_ms, allowance_ms, zero pad
    input  logic [((2*POS_BITS + bafrd_pkg::NOW_BITS + bafrd_pkg::ALLOW_BITS + 7) / 8) * 8 - 1:0]
                 s_axis_tdata,
    // tuser, low bit up: command, pose_valid
    input  logic [1:0] s_axis_tuser,

    // Result stream
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata, low bit up: speed, travelled
    output logic [bafrd_pkg::SPEED_BITS + bafrd_pkg::DIST_BITS - 1:0] m_axis_tdata,
    // tuser, low bit up: status, drive_valid, stop_drive
    output logic [bafrd_pkg::STATUS_BITS + 1:0] m_axis_tuser
);
    import bafrd_pkg::*;

    localparam int ABS_BITS = POS_BITS + 1;
    localparam int CMP_BITS = (ABS_BITS > DIST_BITS ? ABS_BITS : DIST_BITS) + 1;

    // Sequencer, one-hot
    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECIDE = 11'b000_0000_0010,
        S_SQX    = 11'b000_0000_0100,
        S_SQY    = 11'b000_0000_1000,
        S_SUM    = 11'b000_0001_0000,
        S_ROOT1  = 11'b000_0010_0000,
        S_STROKE = 11'b000_0100_0000,
        S_MUL2   = 11'b000_1000_0000,
        S_RAD2   = 11'b001_0000_0000,
        S_ROOT2  = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [FLOOR_BITS-1:0]  floor_reg, floor_next;
    logic [CEIL_BITS-1:0]   ceil_reg, ceil_next;
    logic [ACCEL_BITS-1:0]  accel_reg, accel_next;
    logic [TARGET_BITS-1:0] target_reg, target_next;
    logic [STROKE_BITS-1:0] stroke_reg, stroke_next;

    // Run state kept between beats
    logic [POS_BITS-1:0]    ref_x_reg, ref_x_next;
    logic [POS_BITS-1:0]    ref_y_reg, ref_y_next;
    logic [TARGET_BITS-1:0] cycles_reg, cycles_next;
    logic                   fwd_reg, fwd_next;
    logic [NOW_BITS-1:0]    deadline_reg, deadline_next;
    logic                   limit_reg, limit_next;

    // Latched input beat
    logic                  cmd_reg, cmd_next;
    logic                  pvalid_reg, pvalid_next;
    logic [POS_BITS-1:0]   px_reg, px_next;
    logic [POS_BITS-1:0]   py_reg, py_next;
    logic [NOW_BITS-1:0]   now_reg, now_next;
    logic [ALLOW_BITS-1:0] allow_reg, allow_next;

    // Working registers
    logic [MUL_BITS-1:0]    ax_reg, ax_next;
    logic [MUL_BITS-1:0]    ay_reg, ay_next;
    logic                   sat_reg, sat_next;
    logic [PROD_BITS-1:0]   sqx_reg, sqx_next;
    logic [DIST_BITS-1:0]   dist_reg, dist_next;
    logic [STROKE_BITS-1:0] remain_reg, remain_next;

    // Pending result and output register
    status_t               res_status_reg, res_status_next;
    logic                  res_drive_reg, res_drive_next;
    logic                  res_stop_reg, res_stop_next;
    logic [SPEED_BITS-1:0] res_speed_reg, res_speed_next;
    logic [DIST_BITS-1:0]  res_trav_reg, res_trav_next;

    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic                  m_drive_reg, m_drive_next;
    logic                  m_stop_reg, m_stop_next;
    logic [SPEED_BITS-1:0] m_speed_reg, m_speed_next;
    logic [DIST_BITS-1:0]  m_trav_reg, m_trav_next;

    // Shared units
    logic [MUL_BITS-1:0]  mul_a, mul_b;
    logic [PROD_BITS-1:0] mul_p;
    logic                 sq_start;
    logic [RAD_BITS-1:0]  sq_rad;
    logic                 sq_done;
    logic [ROOT_BITS-1:0] sq_root;

    // Combinational helpers
    logic                  s_fire;
    logic signed [ABS_BITS-1:0] dx, dy;
    logic [ABS_BITS-1:0]   abs_x, abs_y;
    logic [CMP_BITS-1:0]   ext_x, ext_y;
    logic [NOW_BITS-1:0]   time_left;
    logic [ROOT_BITS-1:0]  vel;

    bafrd_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    bafrd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // Signed offsets from the reference, one bit wider than a position
    assign dx    = $signed({px_reg[POS_BITS-1], px_reg}) - $signed({ref_x_reg[POS_BITS-1], ref_x_reg});
    assign dy    = $signed({py_reg[POS_BITS-1], py_reg}) - $signed({ref_y_reg[POS_BITS-1], ref_y_reg});
    assign abs_x = dx[ABS_BITS-1] ? ABS_BITS'(-dx) : ABS_BITS'(dx);
    assign abs_y = dy[ABS_BITS-1] ? ABS_BITS'(-dy) : ABS_BITS'(dy);
    assign ext_x = CMP_BITS'(abs_x);
    assign ext_y = CMP_BITS'(abs_y);

    // Deadline passed when the wrapped time left reads negative
    assign time_left = deadline_reg - now_reg;

    // Clamp the speed root: raise to the floor, then lower to the ceiling
    always_comb begin
        vel = sq_root;
        if (vel < ROOT_BITS'(floor_reg)) begin
            vel = ROOT_BITS'(floor_reg);
        end
        if (vel > ROOT_BITS'(ceil_reg)) begin
            vel = ROOT_BITS'(ceil_reg);
        end
    end

    always_comb begin
        state_next      = state_reg;
        floor_next      = floor_reg;
        ceil_next       = ceil_reg;
        accel_next      = accel_reg;
        target_next     = target_reg;
        stroke_next     = stroke_reg;
        ref_x_next      = ref_x_reg;
        ref_y_next      = ref_y_reg;
        cycles_next     = cycles_reg;
        fwd_next        = fwd_reg;
        deadline_next   = deadline_reg;
        limit_next      = limit_reg;
        cmd_next        = cmd_reg;
        pvalid_next     = pvalid_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        now_next        = now_reg;
        allow_next      = allow_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        sat_next        = sat_reg;
        sqx_next        = sqx_reg;
        dist_next       = dist_reg;
        remain_next     = remain_reg;
        res_status_next = res_status_reg;
        res_drive_next  = res_drive_reg;
        res_stop_next   = res_stop_reg;
        res_speed_next  = res_speed_reg;
        res_trav_next   = res_trav_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_drive_next    = m_drive_reg;
        m_stop_next     = m_stop_reg;
        m_speed_next    = m_speed_reg;
        m_trav_next     = m_trav_reg;
        mul_a           = ax_reg;
        mul_b           = ax_reg;
        sq_start        = 1'b0;
        sq_rad          = RAD_BITS'(sqx_reg) + RAD_BITS'(mul_p);

        // Drop the output beat once taken
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SPEED_FLOOR:   floor_next  = cfg_wdata[FLOOR_BITS-1:0];
                CFG_SPEED_CEILING: ceil_next   = cfg_wdata[CEIL_BITS-1:0];
                CFG_ACCEL_LIMIT:   accel_next  = cfg_wdata[ACCEL_BITS-1:0];
                CFG_CYCLE_TARGET:  target_next = cfg_wdata[TARGET_BITS-1:0];
                CFG_STROKE_LENGTH: stroke_next = cfg_wdata[STROKE_BITS-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    cmd_next    = s_axis_tuser[0];
                    pvalid_next = s_axis_tuser[1];
                    px_next     = s_axis_tdata[POS_BITS-1:0];
                    py_next     = s_axis_tdata[2*POS_BITS-1 -: POS_BITS];
                    now_next    = s_axis_tdata[2*POS_BITS + NOW_BITS - 1 -: NOW_BITS];
                    allow_next  = s_axis_tdata[2*POS_BITS + NOW_BITS + ALLOW_BITS - 1 -: ALLOW_BITS];
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                res_status_next = STATUS_RUNNING;
                res_drive_next  = 1'b0;
                res_stop_next   = 1'b0;
                res_speed_next  = '0;
                res_trav_next   = '0;
                state_next      = S_EMIT;
                if (cmd_reg == CMD_START) begin
                    if (!pvalid_reg) begin
                        res_status_next = STATUS_FAILED;
                    end else begin
                        ref_x_next    = px_reg;
                        ref_y_next    = py_reg;
                        cycles_next   = '0;
                        fwd_next      = 1'b0;
                        deadline_next = now_reg + NOW_BITS'(allow_reg);
                        limit_next    = (allow_reg != '0);
                    end
                end else if (limit_reg && time_left[NOW_BITS-1]) begin
                    res_status_next = STATUS_FAILED;
                    res_stop_next   = 1'b1;
                end else if (cycles_reg >= target_reg) begin
                    res_status_next = STATUS_SUCCEEDED;
                    res_stop_next   = 1'b1;
                end else if (!pvalid_reg) begin
                    res_status_next = STATUS_FAILED;
                end else begin
                    // Saturate when either offset leaves the distance range
                    sat_next   = (ext_x > CMP_BITS'(DIST_SAT)) || (ext_y > CMP_BITS'(DIST_SAT));
                    ax_next    = ext_x[MUL_BITS-1:0];
                    ay_next    = ext_y[MUL_BITS-1:0];
                    state_next = S_SQX;
                end
            end
            S_SQX: begin
                mul_a      = ax_reg;
                mul_b      = ax_reg;
                state_next = S_SQY;
            end
            S_SQY: begin
                mul_a      = ay_reg;
                mul_b      = ay_reg;
                sqx_next   = mul_p;
                state_next = S_SUM;
            end
            S_SUM: begin
                if (sat_reg) begin
                    dist_next  = DIST_SAT;
                    state_next = S_STROKE;
                end else begin
                    sq_start   = 1'b1;
                    state_next = S_ROOT1;
                end
            end
            S_ROOT1: begin
                if (sq_done) begin
                    dist_next  = (sq_root > ROOT_BITS'(DIST_SAT)) ? DIST_SAT
                                                                  : sq_root[DIST_BITS-1:0];
                    state_next = S_STROKE;
                end
            end
            S_STROKE: begin
                // Flip at the stroke length; count a cycle on each switch to forward
                if (dist_reg >= DIST_BITS'(stroke_reg)) begin
                    fwd_next    = !fwd_reg;
                    ref_x_next  = px_reg;
                    ref_y_next  = py_reg;
                    remain_next = '0;
                    if (!fwd_reg) begin
                        cycles_next = cycles_reg + 1'b1;
                    end
                end else begin
                    remain_next = stroke_reg - dist_reg[STROKE_BITS-1:0];
                end
                state_next = S_MUL2;
            end
            S_MUL2: begin
                mul_a      = MUL_BITS'(accel_reg);
                mul_b      = MUL_BITS'(remain_reg);
                state_next = S_RAD2;
            end
            S_RAD2: begin
                sq_start   = 1'b1;
                sq_rad     = RAD_BITS'({mul_p, 1'b0});
                state_next = S_ROOT2;
            end
            S_ROOT2: begin
                if (sq_done) begin
                    res_status_next = STATUS_RUNNING;
                    res_drive_next  = 1'b1;
                    res_stop_next   = 1'b0;
                    res_speed_next  = fwd_reg ? vel[SPEED_BITS-1:0] : -vel[SPEED_BITS-1:0];
                    res_trav_next   = dist_reg;
                    state_next      = S_EMIT;
                end
            end
            S_EMIT: begin
                // Hand over once the output register is free or being emptied
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_drive_next  = res_drive_reg;
                    m_stop_next   = res_stop_reg;
                    m_speed_next  = res_speed_reg;
                    m_trav_next   = res_trav_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control, configuration and run state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            floor_reg    <= FLOOR_RST;
            ceil_reg     <= CEIL_RST;
            accel_reg    <= ACCEL_RST;
            target_reg   <= TARGET_RST;
            stroke_reg   <= STROKE_RST;
            ref_x_reg    <= '0;
            ref_y_reg    <= '0;
            cycles_reg   <= '0;
            fwd_reg      <= 1'b0;
            deadline_reg <= '0;
            limit_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            floor_reg    <= floor_next;
            ceil_reg     <= ceil_next;
            accel_reg    <= accel_next;
            target_reg   <= target_next;
            stroke_reg   <= stroke_next;
            ref_x_reg    <= ref_x_next;
            ref_y_reg    <= ref_y_next;
            cycles_reg   <= cycles_next;
            fwd_reg      <= fwd_next;
            deadline_reg <= deadline_next;
            limit_reg    <= limit_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        pvalid_reg     <= pvalid_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        now_reg        <= now_next;
        allow_reg      <= allow_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        sat_reg        <= sat_next;
        sqx_reg        <= sqx_next;
        dist_reg       <= dist_next;
        remain_reg     <= remain_next;
        res_status_reg <= res_status_next;
        res_drive_reg  <= res_drive_next;
        res_stop_reg   <= res_stop_next;
        res_speed_reg  <= res_speed_next;
        res_trav_reg   <= res_trav_next;
        m_status_reg   <= m_status_next;
        m_drive_reg    <= m_drive_next;
        m_stop_reg     <= m_stop_next;
        m_speed_reg    <= m_speed_next;
        m_trav_reg     <= m_trav_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_trav_reg, m_speed_reg};
    assign m_axis_tuser  = {m_stop_reg, m_drive_reg, m_status_reg};

endmodule

[hdl/bafrd_chk.sv]
module bafrd_chk (
    input logic aclk,
    input logic aresetn,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [bafrd_pkg::SPEED_BITS + bafrd_pkg::DIST_BITS - 1:0] m_axis_tdata,
    input logic [bafrd_pkg::STATUS_BITS + 1:0] m_axis_tuser
);
    import bafrd_pkg::*;

    // The sequencer is busy in the cycle after each accepted beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // A stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // A stop never carries a speed command
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[STATUS_BITS + 1] |->
            !m_axis_tuser[STATUS_BITS] && (m_axis_tdata[SPEED_BITS-1:0] == '0))
        else $error("stop issued with a speed");

    // A speed command is issued only while running
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[STATUS_BITS] |->
            (m_axis_tuser[STATUS_BITS-1:0] == STATUS_RUNNING))
        else $error("speed command outside a running step");

endmodule

bind back_and_forth_recovery_drive_core bafrd_chk u_bafrd_chk (.*);

[dv/tb_back_and_forth_recovery_drive_core.sv]
`timescale 1ns / 1ps

module tb_back_and_forth_recovery_drive_core;
    import bafrd_pkg::*;

    localparam int POS_BITS    = POS_BITS_DEF;
    localparam int IN_W        = ((2*POS_BITS + NOW_BITS + ALLOW_BITS + 7) / 8) * 8;
    localparam int PHASES      = 12;
    localparam int PHASE_BEATS = 150;
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 8;
    localparam int TAIL        = 80;

    localparam logic [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
    localparam logic [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};

    typedef struct packed {
        command_t                 cmd;
        logic                     pose_ok;
        logic [POS_BITS-1:0]      pos_x;
        logic [POS_BITS-1:0]      pos_y;
        logic [NOW_BITS-1:0]      now_ms;
        logic [ALLOW_BITS-1:0]    allow_ms;
    } beat_t;

    typedef struct packed {
        status_t                  status;
        logic                     drive_valid;
        logic                     stop_drive;
        logic [SPEED_BITS-1:0]    speed;
        logic [DIST_BITS-1:0]     travelled;
    } drive_res_t;

    typedef struct packed {
        beat_t      b;
        logic       pinned;     // expectation typed in below
        drive_res_t want;
    } drill_t;

    localparam drive_res_t RES_IDLE    = '{STATUS_RUNNING,   1'b0, 1'b0, 16'd0, 24'd0};
    localparam drive_res_t RES_NO_POSE = '{STATUS_FAILED,    1'b0, 1'b0, 16'd0, 24'd0};
    localparam drive_res_t RES_LATE    = '{STATUS_FAILED,    1'b0, 1'b1, 16'd0, 24'd0};
    localparam drive_res_t RES_DONE    = '{STATUS_SUCCEEDED, 1'b0, 1'b1, 16'd0, 24'd0};

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [IN_W-1:0]               s_axis_tdata  = '0;  // pos_x, pos_y, now_ms, allowance_ms, pad
    logic [1:0]                    s_axis_tuser  = '0;  // command, pose_valid
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [SPEED_BITS+DIST_BITS-1:0] m_axis_tdata;      // speed, travelled
    logic [STATUS_BITS+1:0]        m_axis_tuser;        // status, drive_valid, stop_drive

    back_and_forth_recovery_drive_core #(.POS_BITS(POS_BITS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow of the register file
    logic [FLOOR_BITS-1:0]  cfg_floor   = FLOOR_RST;
    logic [CEIL_BITS-1:0]   cfg_ceiling = CEIL_RST;
    logic [ACCEL_BITS-1:0]  cfg_accel   = ACCEL_RST;
    logic [TARGET_BITS-1:0] cfg_target  = TARGET_RST;
    logic [STROKE_BITS-1:0] cfg_stroke  = STROKE_RST;

    // Shadow of the run state
    logic [POS_BITS-1:0]    run_ref_x      = '0;
    logic [POS_BITS-1:0]    run_ref_y      = '0;
    logic [TARGET_BITS-1:0] pairs_done     = '0;
    logic                   heading_fwd    = 1'b0;
    logic [NOW_BITS-1:0]    deadline       = '0;
    logic                   deadline_armed = 1'b0;

    drive_res_t drive_due[$];
    int  mismatches = 0;
    int  checked    = 0;
    int  beats_sent = 0;
    int  n_flips    = 0;
    int  n_done     = 0;
    int  n_late     = 0;
    int  tx_gap_max = 12;
    int  rx_gap_max = 12;
    int  quiet_cycles = 0;
    logic park_results = 1'b0;

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned root, probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe >>= 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Advance the shadow state by one beat and return the drive command it yields
    function automatic drive_res_t drive_predict(beat_t b);
        drive_res_t      r;
        logic [31:0]     slack;
        logic [POS_BITS:0] dx, dy, ax, ay;
        longint unsigned span, remaining, vel;
        if (b.cmd == CMD_START) begin
            if (!b.pose_ok)
                return RES_NO_POSE;
            run_ref_x      = b.pos_x;
            run_ref_y      = b.pos_y;
            pairs_done     = '0;
            heading_fwd    = 1'b0;
            deadline       = b.now_ms + NOW_BITS'(b.allow_ms);
            deadline_armed = (b.allow_ms != '0);
            return RES_IDLE;
        end
        slack = deadline - b.now_ms;
        if (deadline_armed && slack[31]) begin
            n_late++;
            return RES_LATE;
        end
        if (pairs_done >= cfg_target) begin
            n_done++;
            return RES_DONE;
        end
        if (!b.pose_ok)
            return RES_NO_POSE;

        dx   = {b.pos_x[POS_BITS-1], b.pos_x} - {run_ref_x[POS_BITS-1], run_ref_x};
        dy   = {b.pos_y[POS_BITS-1], b.pos_y} - {run_ref_y[POS_BITS-1], run_ref_y};
        ax   = dx[POS_BITS] ? -dx : dx;
        ay   = dy[POS_BITS] ? -dy : dy;
        span = root_floor(64'(ax) * 64'(ax) + 64'(ay) * 64'(ay));
        if (span > 64'(DIST_SAT))
            span = 64'(DIST_SAT);

        // stroke reached: turn round and re-anchor, a pair ends on each turn to forward
        if (span >= 64'(cfg_stroke)) begin
            heading_fwd = !heading_fwd;
            run_ref_x   = b.pos_x;
            run_ref_y   = b.pos_y;
            n_flips++;
            if (heading_fwd)
                pairs_done = pairs_done + 8'd1;
        end
        remaining = (span < 64'(cfg_stroke)) ? 64'(cfg_stroke) - span : 64'd0;
        vel = root_floor(64'd2 * 64'(cfg_accel) * remaining);
        if (vel < 64'(cfg_floor))
            vel = 64'(cfg_floor);
        if (vel > 64'(cfg_ceiling))
            vel = 64'(cfg_ceiling);

        r.status      = STATUS_RUNNING;
        r.drive_valid = 1'b1;
        r.stop_drive  = 1'b0;
        r.speed       = heading_fwd ? vel[SPEED_BITS-1:0] : 16'd0 - vel[SPEED_BITS-1:0];
        r.travelled   = span[DIST_BITS-1:0];
        return r;
    endfunction

    function automatic beat_t beat(command_t cmd, logic ok, logic [POS_BITS-1:0] x,
                                   logic [POS_BITS-1:0] y, logic [NOW_BITS-1:0] now,
                                   logic [ALLOW_BITS-1:0] allow);
        beat_t b;
        b.cmd      = cmd;
        b.pose_ok  = ok;
        b.pos_x    = x;
        b.pos_y    = y;
        b.now_ms   = now;
        b.allow_ms = allow;
        return b;
    endfunction

    // Offer one beat after a random gap; log its expectation once it is taken
    task automatic offer_beat(input beat_t b, input logic pinned, input drive_res_t want);
        int gap;
        drive_res_t guess;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({b.allow_ms, b.now_ms, b.pos_y, b.pos_x});
        s_axis_tuser  <= {b.pose_ok, b.cmd};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        guess = drive_predict(b);
        drive_due.push_back(pinned ? want : guess);
        beats_sent++;
    endtask

    // Hold the input back until every command has come out, then let the core go idle
    task automatic settle(input int extra);
        s_axis_tvalid <= 1'b0;
        while (drive_due.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [FLOOR_BITS-1:0] floor_v,
                                 input logic [CEIL_BITS-1:0] ceil_v,
                                 input logic [ACCEL_BITS-1:0] accel_v,
                                 input logic [TARGET_BITS-1:0] target_v,
                                 input logic [STROKE_BITS-1:0] stroke_v);
        settle(SETTLE);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_SPEED_FLOOR;
        cfg_wdata <= CFG_DATA_BITS'(floor_v);
        @(posedge aclk);
        cfg_addr  <= CFG_SPEED_CEILING;
        cfg_wdata <= CFG_DATA_BITS'(ceil_v);
        @(posedge aclk);
        cfg_addr  <= CFG_ACCEL_LIMIT;
        cfg_wdata <= CFG_DATA_BITS'(accel_v);
        @(posedge aclk);
        cfg_addr  <= CFG_CYCLE_TARGET;
        cfg_wdata <= CFG_DATA_BITS'(target_v);
        @(posedge aclk);
        cfg_addr  <= CFG_STROKE_LENGTH;
        cfg_wdata <= CFG_DATA_BITS'(stroke_v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_floor   = floor_v;
        cfg_ceiling = ceil_v;
        cfg_accel   = accel_v;
        cfg_target  = target_v;
        cfg_stroke  = stroke_v;
        @(posedge aclk);
    endtask

    // Result side: random back-pressure, with one long park on request
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (park_results) begin
                stall = LONG_HOLD;
                park_results = 1'b0;
            end else begin
                stall = $urandom_range(0, rx_gap_max);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge aclk) begin : result_check
        drive_res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (drive_due.size() == 0) begin
                $error("unexpected drive result tuser=%h tdata=%h", m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                want = drive_due.pop_front();
                checked++;
                if (m_axis_tuser[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser[1:0]);
                    mismatches++;
                end
                if (m_axis_tuser[2] !== want.drive_valid) begin
                    $error("drive_valid: expected %0d, got %0d", want.drive_valid,
                           m_axis_tuser[2]);
                    mismatches++;
                end
                if (m_axis_tuser[3] !== want.stop_drive) begin
                    $error("stop_drive: expected %0d, got %0d", want.stop_drive, m_axis_tuser[3]);
                    mismatches++;
                end
                if (m_axis_tdata[SPEED_BITS-1:0] !== want.speed) begin
                    $error("speed: expected %0d, got %0d", $signed(want.speed),
                           $signed(m_axis_tdata[SPEED_BITS-1:0]));
                    mismatches++;
                end
                if (m_axis_tdata[SPEED_BITS +: DIST_BITS] !== want.travelled) begin
                    $error("travelled: expected %0d, got %0d", want.travelled,
                           m_axis_tdata[SPEED_BITS +: DIST_BITS]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if neither side moves a beat for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        drill_t drill[$];
        beat_t  b;
        logic [POS_BITS-1:0] walk_x, walk_y;
        logic [NOW_BITS-1:0] clock_ms;
        logic   last_heading;
        int     head_x, head_y, step, seq_left, roll;

        // Directed part, on the reset settings. Pinned rows are obvious at a glance.
        drill.push_back('{beat(CMD_TICK,  1'b0, 24'd0, 24'd0, 32'd0, 31'd0), 1'b1, RES_NO_POSE});
        // tick before any start runs on the cleared state
        drill.push_back('{beat(CMD_TICK,  1'b1, 24'd0, 24'd0, 32'd5, 31'd0), 1'b0, RES_IDLE});
        drill.push_back('{beat(CMD_START, 1'b0, 24'd5, 24'd5, 32'd9, 31'd7), 1'b1, RES_NO_POSE});
        drill.push_back('{beat(CMD_START, 1'b1, 24'd0, 24'd0, 32'd1000, 31'd0), 1'b1, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b1, 24'd0, 24'd0, 32'd1010, 31'd0), 1'b0, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b1, 24'd100, 24'd50, 32'd1020, 31'd0), 1'b0, RES_IDLE});
        // exactly one stroke out: turn to forward at the floor speed
        drill.push_back('{beat(CMD_TICK,  1'b1, 24'd300, 24'd0, 32'd1030, 31'd0), 1'b0, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b0, 24'd300, 24'd0, 32'd1040, 31'd0), 1'b1, RES_NO_POSE});
        // corner to corner: distance saturates
        drill.push_back('{beat(CMD_TICK,  1'b1, POS_MIN, POS_MIN, 32'd1050, 31'd0), 1'b0, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b1, POS_MAX, POS_MAX, 32'd1060, 31'd0), 1'b0, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b1, POS_MIN, POS_MIN, 32'd1070, 31'd0), 1'b0, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b1, POS_MAX, POS_MAX, 32'd1080, 31'd0), 1'b0, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b1, 24'd0, 24'd0, 32'd1090, 31'd0), 1'b1, RES_DONE});
        // deadline wraps past 2^32
        drill.push_back('{beat(CMD_START, 1'b1, POS_MAX, POS_MIN, 32'hFFFF_FF00, 31'h7FFF_FFFF),
                          1'b1, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b1, POS_MAX, POS_MIN, 32'h7FFF_FEFF, 31'd0),
                          1'b0, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b1, POS_MAX, POS_MIN, 32'h7FFF_FF00, 31'd0),
                          1'b1, RES_LATE});
        drill.push_back('{beat(CMD_START, 1'b1, '1, '1, 32'd0, 31'd1), 1'b1, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b1, '1, '1, 32'd1, 31'd0), 1'b0, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b1, '1, '1, 32'd2, 31'd0), 1'b1, RES_LATE});
        // no allowance: time never runs out
        drill.push_back('{beat(CMD_START, 1'b1, 24'd7, 24'd7, 32'd0, 31'd0), 1'b1, RES_IDLE});
        drill.push_back('{beat(CMD_TICK,  1'b1, 24'd7, 24'd90, 32'hFFFF_FFFF, 31'h7FFF_FFFF),
                          1'b0, RES_IDLE});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (drill[i])
            offer_beat(drill[i].b, drill[i].pinned, drill[i].want);

        walk_x = '0; walk_y = '0; clock_ms = '0;
        head_x = 1; head_y = 0; last_heading = 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: load_settings('0, '0, '0, '0, '0);
                1: load_settings('1, '1, '1, '1, '1);
                2: load_settings(15'd400, 15'd150, 16'($urandom()), 8'd2, 16'd40);
                3: load_settings(15'd0, '1, '1, 8'd4, 16'd1);
                default: load_settings(15'($urandom_range(0, 600)),
                                       15'($urandom_range(0, 3000)),
                                       16'($urandom()), 8'($urandom_range(1, 5)),
                                       ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                                   : 16'($urandom_range(1, 200)));
            endcase
            tx_gap_max = (p % 3 == 1) ? 0 : 12;
            rx_gap_max = (p % 4 == 2) ? 0 : 12;
            seq_left = 0;

            for (int i = 0; i < PHASE_BEATS; i++) begin
                // park the result side while beats keep coming
                if (p == 2 && i == 10)
                    park_results = 1'b1;
                // one mid-phase pause with everything drained
                if (p == 5 && i == 75)
                    settle(0);

                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    // noise: anything the fields allow
                    b = beat(command_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             24'($urandom()), 24'($urandom()), $urandom(), 31'($urandom()));
                end else if (seq_left == 0) begin
                    // open a new run from a fresh spot, heading somewhere
                    seq_left = $urandom_range(4, 40);
                    walk_x = 24'($urandom());
                    walk_y = 24'($urandom());
                    do begin
                        head_x = $urandom_range(0, 2) - 1;
                        head_y = $urandom_range(0, 2) - 1;
                    end while (head_x == 0 && head_y == 0);
                    if ($urandom_range(0, 3) == 0)
                        clock_ms = $urandom();
                    case ($urandom_range(0, 2))
                        0: b = beat(CMD_START, 1'b1, walk_x, walk_y, clock_ms, 31'd0);
                        1: b = beat(CMD_START, 1'b1, walk_x, walk_y, clock_ms,
                                    31'($urandom_range(20, 800)));
                        default: b = beat(CMD_START, 1'b1, walk_x, walk_y, clock_ms,
                                          31'($urandom()));
                    endcase
                    if ($urandom_range(0, 19) == 0)
                        b.pose_ok = 1'b0;
                    last_heading = 1'b0;
                end else begin
                    // walk along the heading, turning round whenever the drive does
                    seq_left--;
                    if (heading_fwd != last_heading) begin
                        head_x = -head_x;
                        head_y = -head_y;
                        last_heading = heading_fwd;
                    end
                    step = $urandom_range(0, int'(cfg_stroke) / 4 + 3);
                    walk_x = walk_x + POS_BITS'(head_x * step);
                    walk_y = walk_y + POS_BITS'(head_y * step);
                    clock_ms = clock_ms + NOW_BITS'($urandom_range(0, 40));
                    b = beat(CMD_TICK, ($urandom_range(0, 19) != 0), walk_x, walk_y,
                             clock_ms, 31'($urandom()));
                end
                offer_beat(b, 1'b0, RES_IDLE);
            end
        end

        settle(TAIL);
        $display("Checked %0d drive results from %0d beats over %0d register settings.",
                 checked, beats_sent, PHASES + 1);
        $display("Saw %0d turns, %0d completed runs and %0d deadline stops.",
                 n_flips, n_done, n_late);
        if (mismatches == 0 && drive_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/bafrd_pkg.sv
hdl/bafrd_mul.sv
hdl/bafrd_sqrt.sv
hdl/back_and_forth_recovery_drive_core.sv
hdl/bafrd_chk.sv
dv/tb_back_and_forth_recovery_drive_core.sv
